// File: rtl/core/bc1_bc3_block_decoder_unit_macros.svh
// Assertion macros shared by the block decoder checker.
`ifndef BC1_BC3_BLOCK_DECODER_UNIT_MACROS_SVH
`define BC1_BC3_BLOCK_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BC13_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BC13_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bc13_pkg.sv
// Types, constants and arithmetic helpers of the block decoder.
`default_nettype none

package bc13_pkg;

    localparam int PIXELS_PER_BLOCK = 4 * 4;
    localparam int PIX_IDX_W        = $clog2(PIXELS_PER_BLOCK);
    localparam logic [PIX_IDX_W-1:0] LAST_PIX_IDX = PIX_IDX_W'(PIXELS_PER_BLOCK - 1);

    localparam int COLOR_IDX_W = 2;
    localparam int ALPHA_IDX_W = 3;
    localparam int COLOR_ENTRIES = 4;
    localparam int ALPHA_ENTRIES = 8;
    localparam int CHANNELS = 3;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    localparam int Max5 = 'h1F;
    localparam int Max6 = 'h3F;
    localparam int FullScale = 255;

    localparam logic [7:0] ALPHA_ZERO = 8'h00;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;
    localparam logic [7:0] COLOR_BLACK = 8'h00;

    localparam logic FMT_BC1 = 1'b0;
    localparam logic FMT_BC3 = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } blk_item_t;

    typedef struct packed {
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [7:0]           alpha;
        logic                 last_pixel;
    } pix_item_t;

    // One decoded block: both palettes plus the per-pixel indices.
    typedef struct packed {
        logic [COLOR_ENTRIES-1:0][CHANNELS-1:0][7:0]    color_pal;
        logic [ALPHA_ENTRIES-1:0][7:0]                  alpha_pal;
        logic [PIXELS_PER_BLOCK*COLOR_IDX_W-1:0]        color_idx;
        logic [PIXELS_PER_BLOCK*ALPHA_IDX_W-1:0]        alpha_idx;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef logic [7:0] exp5_lut_t [Max5+1];
    typedef logic [7:0] exp6_lut_t [Max6+1];

    function automatic exp5_lut_t build_exp5();
        exp5_lut_t lut;
        for (int i = 0; i <= Max5; i++)
        begin
            lut[i] = 8'(i * FullScale / Max5);
        end
        return lut;
    endfunction

    function automatic exp6_lut_t build_exp6();
        exp6_lut_t lut;
        for (int i = 0; i <= Max6; i++)
        begin
            lut[i] = 8'(i * FullScale / Max6);
        end
        return lut;
    endfunction

    localparam exp5_lut_t EXP5_LUT = build_exp5();
    localparam exp6_lut_t EXP6_LUT = build_exp6();

    // x / 3 for x < 768: x * 683 >> 11.
    function automatic logic [7:0] div3(logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // x / 7 for x < 1792: x * 2341 >> 14.
    function automatic logic [7:0] div7(logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

    // x / 5 for x < 1280: x * 1639 >> 13.
    function automatic logic [7:0] div5(logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd1639;
        return p[20:13];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bc1_bc3_block_decoder_unit.sv
// Top level of the BC1/BC3 texture block decoder.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------
//  blk      | in  | blk_valid / blk_stall | blk_item_t: color and alpha words
//  pix      | out | pix_valid / pix_stall | pix_item_t: one RGBA pixel
//  format   | in  | format_we             | format_data: 0 BC1, 1 BC3
//
// A block is held in the palette stage register, then sits in a two-entry queue.
// The back end sends one pixel a cycle while a block is queued and not stalled;
// the front can take a new block before the last one has been fully sent.
// The first pixel passes the palette register, queue and output register.
// rst_n clears all valid flags, queue pointers and format_mode to BC1.
// pix_stall holds the back end only; the front keeps filling the queue.
`default_nettype none

module bc1_bc3_block_decoder_unit
    import bc13_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      blk_valid,
    output logic           blk_stall,
    input  wire blk_item_t blk,
    output logic           pix_valid,
    input  wire logic      pix_stall,
    output pix_item_t      pix,
    input  wire logic      format_we,
    input  wire logic      format_data
);

    logic      format_mode_reg, format_mode_next;
    logic      push, pop;
    q_entry_t  wr_entry, rd_entry;
    q_status_t q_stat;

    assign format_mode_next = format_we ? format_data : format_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= FMT_BC1;
        end
        else
        begin
            format_mode_reg <= format_mode_next;
        end
    end

    bc13_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk),
        .q_stat    (q_stat),
        .push      (push),
        .entry     (wr_entry)
    );

    bc13_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .stat     (q_stat)
    );

    bc13_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (format_mode_reg),
        .rd_entry  (rd_entry),
        .q_stat    (q_stat),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule

`default_nettype wire

// File: rtl/core/bc13_front.sv
// Front end: accepts blocks, expands endpoints and builds both palettes.
`default_nettype none

module bc13_front
    import bc13_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      blk_valid,
    output logic           blk_stall,
    input  wire blk_item_t blk,
    input  wire q_status_t q_stat,
    output logic           push,
    output q_entry_t       entry
);

    localparam int ASUMS = ALPHA_ENTRIES - 2;

    typedef struct packed {
        logic [CHANNELS-1:0][7:0]         p0;
        logic [CHANNELS-1:0][7:0]         p1;
        logic [CHANNELS-1:0][9:0]         sum_a;
        logic [CHANNELS-1:0][9:0]         sum_b;
        logic                             four_color;
        logic [7:0]                       a0;
        logic [7:0]                       a1;
        logic                             eight_alpha;
        logic [ASUMS-1:0][10:0]           asum;
        logic [PIXELS_PER_BLOCK*COLOR_IDX_W-1:0] color_idx;
        logic [PIXELS_PER_BLOCK*ALPHA_IDX_W-1:0] alpha_idx;
    } stage_t;

    logic   s1_valid_reg, s1_valid_next;
    stage_t s1_reg, s1_next;
    logic   accept;

    logic [15:0] c0, c1;
    logic [CHANNELS-1:0][7:0] e0, e1;

    function automatic logic [10:0] wsum(logic [7:0] x, logic [7:0] y,
                                         logic [2:0] wx, logic [2:0] wy);
        return 11'(x) * 11'(wx) + 11'(y) * 11'(wy);
    endfunction

    assign blk_stall = s1_valid_reg && q_stat.full;
    assign push      = s1_valid_reg && !q_stat.full;
    assign accept    = blk_valid && !blk_stall;

    always_comb
    begin
        c0 = blk.color_block[15:0];
        c1 = blk.color_block[31:16];
        e0[CH_R] = EXP5_LUT[c0[15:11]];
        e0[CH_G] = EXP6_LUT[c0[10:5]];
        e0[CH_B] = EXP5_LUT[c0[4:0]];
        e1[CH_R] = EXP5_LUT[c1[15:11]];
        e1[CH_G] = EXP6_LUT[c1[10:5]];
        e1[CH_B] = EXP5_LUT[c1[4:0]];

        s1_next.p0         = e0;
        s1_next.p1         = e1;
        s1_next.four_color = c0 > c1;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            // Three-color mode keeps the plain sum for the halfway entry.
            if (c0 > c1)
            begin
                s1_next.sum_a[ch] = {1'b0, e0[ch], 1'b0} + 10'(e1[ch]);
            end
            else
            begin
                s1_next.sum_a[ch] = 10'(e0[ch]) + 10'(e1[ch]);
            end
            s1_next.sum_b[ch] = 10'(e0[ch]) + {1'b0, e1[ch], 1'b0};
        end

        s1_next.a0          = blk.alpha_block[7:0];
        s1_next.a1          = blk.alpha_block[15:8];
        s1_next.eight_alpha = blk.alpha_block[7:0] > blk.alpha_block[15:8];
        for (int j = 0; j < ASUMS; j++)
        begin
            if (s1_next.eight_alpha)
            begin
                s1_next.asum[j] = wsum(s1_next.a0, s1_next.a1, 3'(6 - j), 3'(j + 1));
            end
            else if (j < 4)
            begin
                s1_next.asum[j] = wsum(s1_next.a0, s1_next.a1, 3'(4 - j), 3'(j + 1));
            end
            else
            begin
                s1_next.asum[j] = '0;
            end
        end

        s1_next.color_idx = blk.color_block[63:32];
        s1_next.alpha_idx = blk.alpha_block[63:16];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // Finish the divides; the queue registers the result.
    always_comb
    begin
        entry.color_pal[0] = s1_reg.p0;
        entry.color_pal[1] = s1_reg.p1;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (s1_reg.four_color)
            begin
                entry.color_pal[2][ch] = div3(s1_reg.sum_a[ch]);
                entry.color_pal[3][ch] = div3(s1_reg.sum_b[ch]);
            end
            else
            begin
                entry.color_pal[2][ch] = s1_reg.sum_a[ch][8:1];
                entry.color_pal[3][ch] = COLOR_BLACK;
            end
        end

        entry.alpha_pal[0] = s1_reg.a0;
        entry.alpha_pal[1] = s1_reg.a1;
        for (int j = 0; j < ASUMS; j++)
        begin
            if (s1_reg.eight_alpha)
            begin
                entry.alpha_pal[j + 2] = div7(s1_reg.asum[j]);
            end
            else if (j < 4)
            begin
                entry.alpha_pal[j + 2] = div5(s1_reg.asum[j]);
            end
            else if (j == 4)
            begin
                entry.alpha_pal[j + 2] = ALPHA_ZERO;
            end
            else
            begin
                entry.alpha_pal[j + 2] = ALPHA_FULL;
            end
        end

        entry.color_idx = s1_reg.color_idx;
        entry.alpha_idx = s1_reg.alpha_idx;
    end

endmodule

`default_nettype wire

// File: rtl/core/bc13_queue.sv
// Short queue of decoded blocks between the front and back ends.
`default_nettype none

module bc13_queue
    import bc13_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t wr_entry,
    input  wire logic     pop,
    output q_entry_t      rd_entry,
    output q_status_t     stat
);

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign rd_entry   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bc13_back.sv
// Back end: walks the sixteen pixels of the head block into the output register.
`default_nettype none

module bc13_back
    import bc13_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      mode,
    input  wire q_entry_t  rd_entry,
    input  wire q_status_t q_stat,
    output logic           pop,
    output logic           pix_valid,
    input  wire logic      pix_stall,
    output pix_item_t      pix
);

    logic [PIX_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    pix_item_t            out_reg, out_next;
    logic                 emit;
    logic [COLOR_IDX_W-1:0] ci;
    logic [ALPHA_IDX_W-1:0] ai;
    logic [PIX_IDX_W:0]     c_pos;
    logic [PIX_IDX_W+1:0]   a_pos;

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    // Load the output register when a block is queued and the register is empty or being taken.
    assign emit = !q_stat.empty && (!out_valid_reg || !pix_stall);
    assign pop  = emit && (cnt_reg == LAST_PIX_IDX);

    always_comb
    begin
        c_pos = {cnt_reg, 1'b0};
        a_pos = {1'b0, cnt_reg, 1'b0} + {2'b00, cnt_reg};
        ci    = rd_entry.color_idx[c_pos +: COLOR_IDX_W];
        ai    = rd_entry.alpha_idx[a_pos +: ALPHA_IDX_W];

        out_next.pixel_index = cnt_reg;
        out_next.red         = rd_entry.color_pal[ci][CH_R];
        out_next.green       = rd_entry.color_pal[ci][CH_G];
        out_next.blue        = rd_entry.color_pal[ci][CH_B];
        out_next.alpha       = (mode == FMT_BC3) ? rd_entry.alpha_pal[ai] : ALPHA_FULL;
        out_next.last_pixel  = cnt_reg == LAST_PIX_IDX;
    end

    always_comb
    begin
        cnt_next       = emit ? cnt_reg + 1'b1 : cnt_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pix_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bc13_checker.sv
// Port-level checker for the block decoder, bound to the top level.
`default_nettype none
`include "bc1_bc3_block_decoder_unit_macros.svh"

module bc13_checker
    import bc13_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      blk_valid,
    input wire logic      blk_stall,
    input wire logic      pix_valid,
    input wire logic      pix_stall,
    input wire pix_item_t pix,
    input wire logic      format_we,
    input wire logic      format_data
);

    logic [PIX_IDX_W-1:0] exp_idx_reg, exp_idx_next;
    logic                 mode_reg, mode_next;
    logic                 pix_take;
    logic                 blk_take;
    logic                 pix_wait;
    logic                 last_idx;
    logic                 bc1_pix;
    logic                 idle_start;

    assign pix_take   = pix_valid && !pix_stall;
    assign blk_take   = blk_valid && !blk_stall;
    assign pix_wait   = pix_valid && pix_stall;
    assign last_idx   = pix.pixel_index == LAST_PIX_IDX;
    assign bc1_pix    = pix_valid && (mode_reg == FMT_BC1);
    assign idle_start = !blk_take && !pix_valid;

    always_comb
    begin
        exp_idx_next = exp_idx_reg;
        if (pix_take)
        begin
            exp_idx_next = pix.last_pixel ? '0 : exp_idx_reg + 1'b1;
        end
        mode_next = format_we ? format_data : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            mode_reg    <= FMT_BC1;
        end
        else
        begin
            exp_idx_reg <= exp_idx_next;
            mode_reg    <= mode_next;
        end
    end

    `BC13_ASSERT_NXT(a_pix_hold, pix_wait, pix_valid && $stable(pix), "stalled pixel changed")
    `BC13_ASSERT_IMP(a_pix_order, pix_valid, pix.pixel_index == exp_idx_reg, "pixel out of order")
    `BC13_ASSERT_IMP(a_last_flag, pix_valid, pix.last_pixel == last_idx, "bad last_pixel flag")
    `BC13_ASSERT_IMP(a_bc1_alpha, bc1_pix, pix.alpha == ALPHA_FULL, "alpha not opaque in BC1")
    `BC13_ASSERT_NXT(a_reset_idle, idle_start && $past(!rst_n), !pix_valid, "pixel without a block")

endmodule

bind bc1_bc3_block_decoder_unit bc13_checker u_bc13_checker (.*);

`default_nettype wire
